// ===== hdl/vvr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvr_pkg - shared types and constants for the view vector rotator
// Beat formats, register indexes, fixed point constants and the arctangent
// table of the CORDIC.
// ----------------------------------------------------------------------------
package vvr_pkg;

	// vector components are Q2.14 at the default width
	localparam int VVR_VEC_W    = 16;
	localparam int VVR_RATE_W   = 16;   // rotation rate, unsigned Q4.12
	localparam int VVR_TIME_W   = 16;   // frame time, unsigned Q0.16
	localparam int VVR_CFG_W    = (VVR_VEC_W > VVR_RATE_W) ? VVR_VEC_W : VVR_RATE_W;
	localparam int VVR_IDX_W    = 3;
	localparam int VVR_LANES    = 4;    // dir x, dir y, plane x, plane y
	localparam int VVR_CORDIC_STEPS = 16;

	// rate * time, then shifted left by two into Q.30: this is the datapath width
	localparam int VVR_PROD_W   = VVR_RATE_W + VVR_TIME_W;
	localparam int VVR_CW       = VVR_PROD_W + 2;
	// serial multiply accumulator and full product widths
	localparam int VVR_HW       = VVR_CW + 1;
	localparam int VVR_PW       = VVR_HW + VVR_VEC_W;
	localparam int VVR_BCNT_W   = $clog2(VVR_VEC_W);
	localparam int VVR_FRAC     = 30;

	localparam logic signed [VVR_CW-1:0] VVR_ANGLE_MAX = VVR_CW'(64'd1686629713); // pi/2
	localparam logic signed [VVR_CW-1:0] VVR_GAIN      = VVR_CW'(64'd652032874);
	localparam logic [VVR_PW-1:0]        VVR_HALF      = VVR_PW'(64'd536870912);

	// reset values of the start registers
	localparam logic [VVR_VEC_W-1:0] VVR_RST_DIR_X   = VVR_VEC_W'(-16384);
	localparam logic [VVR_VEC_W-1:0] VVR_RST_DIR_Y   = VVR_VEC_W'(0);
	localparam logic [VVR_VEC_W-1:0] VVR_RST_PLANE_X = VVR_VEC_W'(0);
	localparam logic [VVR_VEC_W-1:0] VVR_RST_PLANE_Y = VVR_VEC_W'(10813);
	localparam logic [VVR_RATE_W-1:0] VVR_RST_RATE   = VVR_RATE_W'(12288);

	typedef enum logic [VVR_IDX_W-1:0] {
		REG_RATE    = 3'd0,
		REG_DIR_X   = 3'd1,
		REG_DIR_Y   = 3'd2,
		REG_PLANE_X = 3'd3,
		REG_PLANE_Y = 3'd4
	} vvr_reg_t;

	// atan(2^-k) in Q.30
	localparam logic [31:0] VVR_ATAN [32] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
		32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
		32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
		32'd262143,    32'd131071,    32'd65535,     32'd32767,
		32'd16383,     32'd8191,      32'd4095,      32'd2047,
		32'd1023,      32'd511,       32'd255,       32'd127,
		32'd63,        32'd31,        32'd15,        32'd8,
		32'd4,         32'd2,         32'd1,         32'd0
	};

	typedef struct packed {
		logic                  turn_right;
		logic                  turn_left;
		logic [VVR_TIME_W-1:0] frame_time;
	} vvr_in_t;

	typedef struct packed {
		logic                        moved;
		logic signed [VVR_VEC_W-1:0] out_dir_x;
		logic signed [VVR_VEC_W-1:0] out_dir_y;
		logic signed [VVR_VEC_W-1:0] out_plane_x;
		logic signed [VVR_VEC_W-1:0] out_plane_y;
	} vvr_out_t;

endpackage

// ===== hdl/view_vector_rotator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// view_vector_rotator - turns view direction and camera plane per frame
// Step angle = rate * frame time (clamped to pi/2), sine/cosine by an
// iterative CORDIC, then both vectors turned by bit-serial multiplies.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | beat
//  ---------+----------------------------------+------------------------------
//  item     | item_valid, item_stall, item     | keys + frame time (vvr_in_t)
//  result   | result_valid, result_stall,      | moved + four vector parts
//           | result                           | (vvr_out_t)
//  config   | cfg_we, cfg_idx, cfg_data        | one register write per edge
//
// With no key the beat goes straight to the result; one key adds the angle,
// CORDIC, setup, one rotation pass and write-back, both keys a second pass.
// The CORDIC runs one iteration a cycle; each rotation pass then shifts the
// vector parts out one bit a cycle into four shift-add accumulators.
// Reset puts the vectors at the start register reset values; no sweep.
// A finished beat sits in the result register while the next item is taken;
// the engine only waits in its done state if the register is full and stalled.
//
module view_vector_rotator
	import vvr_pkg::*;
#(
	parameter int CORDIC_STEPS = VVR_CORDIC_STEPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// item channel
	input  logic                 item_valid,
	output logic                 item_stall,
	input  vvr_in_t              item,
	// result channel
	output logic                 result_valid,
	input  logic                 result_stall,
	output vvr_out_t             result,
	// configuration
	input  logic                 cfg_we,
	input  logic [VVR_IDX_W-1:0] cfg_idx,
	input  logic [VVR_CFG_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(CORDIC_STEPS);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_ANGLE  = 6'b000010,
		ST_CORDIC = 6'b000100,
		ST_SETUP  = 6'b001000,
		ST_ROTATE = 6'b010000,
		ST_WRITE  = 6'b100000
	} state_t;
	// done state kept apart so the one-hot set stays readable
	localparam state_t ST_NONE = ST_IDLE;

	state_t state_q;
	logic   done_q;          // waiting to hand the beat to the result register
	logic   right_q, left_q;
	logic   pass_left_q;     // current rotation pass uses the negated sine
	logic [CNT_W-1:0]      cnt_q;
	logic [VVR_BCNT_W-1:0] bcnt_q;
	logic                  last_bit;

	logic [VVR_RATE_W-1:0] rate_q;
	logic [VVR_VEC_W-1:0]  vec_q [VVR_LANES];  // state, doubles as bit shifter

	logic [VVR_PROD_W-1:0]      prod_q;
	logic signed [VVR_CW-1:0]   x_q, y_q, z_q;  // x ends as cosine, y as sine
	logic signed [VVR_CW-1:0]   s_q, sn_q;      // sine for this pass and its negation
	logic signed [VVR_HW-1:0]   h_q [VVR_LANES];
	logic [VVR_VEC_W-1:0]       l_q [VVR_LANES];
	vvr_out_t                   result_q;
	logic                       result_valid_q;

	logic                       accept;
	logic                       load_result;
	logic [VVR_CW-1:0]          ang_raw;
	logic signed [VVR_CW-1:0]   ang_clamp;
	logic [4:0]                 k;
	logic signed [VVR_CW-1:0]   dx, dy, at, x_n, y_n, z_n;

	logic signed [VVR_HW:0]     lane_t   [VVR_LANES];
	logic [VVR_VEC_W-1:0]       lane_sat [VVR_LANES];

	function automatic logic [VVR_VEC_W-1:0] sat_vec(input logic signed [VVR_PW-1:0] v);
		logic [VVR_PW-VVR_VEC_W:0] top;
		top = v[VVR_PW-1:VVR_VEC_W-1];
		if ((&top) || !(|top))
			sat_vec = v[VVR_VEC_W-1:0];
		else if (v[VVR_PW-1])
			sat_vec = {1'b1, {(VVR_VEC_W-1){1'b0}}};
		else
			sat_vec = {1'b0, {(VVR_VEC_W-1){1'b1}}};
	endfunction

	assign item_stall   = (state_q != ST_IDLE) || done_q;
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign load_result  = done_q && (!result_valid_q || !result_stall);
	assign last_bit     = (bcnt_q == VVR_BCNT_W'(VVR_VEC_W - 1));

	// angle in Q.30, clamped to pi/2
	assign ang_raw   = {prod_q, 2'b00};
	assign ang_clamp = (ang_raw > VVR_ANGLE_MAX) ? VVR_ANGLE_MAX : ang_raw;

	// one CORDIC iteration, rotation mode
	always_comb begin
		k  = 5'(cnt_q);
		dx = y_q >>> k;
		dy = x_q >>> k;
		at = VVR_CW'(VVR_ATAN[k]);
		if (!z_q[VVR_CW-1]) begin
			x_n = x_q - dx;
			y_n = y_q + dy;
			z_n = z_q - at;
		end else begin
			x_n = x_q + dx;
			y_n = y_q - dy;
			z_n = z_q + at;
		end
	end

	// Lanes: even lane new_x = x*c + y*(-s), odd lane new_y = x*s + y*c.
	// Bits come LSB first; the sign bit has negative weight.
	for (genvar g = 0; g < VVR_LANES; g++) begin : g_lane
		localparam int P = g / 2;
		logic                      xb, yb;
		logic signed [VVR_CW-1:0]  ca, cb;
		logic [VVR_HW-1:0]         sum;
		logic signed [VVR_PW-1:0]  prod, rsum, rnd;

		assign xb   = vec_q[2*P][0];
		assign yb   = vec_q[2*P+1][0];
		assign ca   = (g % 2 == 0) ? x_q  : s_q;
		assign cb   = (g % 2 == 0) ? sn_q : x_q;
		assign sum  = (xb ? {ca[VVR_CW-1], ca} : '0) + (yb ? {cb[VVR_CW-1], cb} : '0);
		assign lane_t[g] = last_bit ? ({h_q[g][VVR_HW-1], h_q[g]} - {sum[VVR_HW-1], sum})
		                            : ({h_q[g][VVR_HW-1], h_q[g]} + {sum[VVR_HW-1], sum});
		assign prod = {h_q[g], l_q[g]};
		assign rsum = prod + VVR_HALF;
		assign rnd  = rsum >>> VVR_FRAC;
		assign lane_sat[g] = sat_vec(rnd);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			done_q         <= 1'b0;
			right_q        <= 1'b0;
			left_q         <= 1'b0;
			pass_left_q    <= 1'b0;
			cnt_q          <= '0;
			bcnt_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (load_result) begin
				result_valid_q <= 1'b1;
				done_q         <= 1'b0;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						right_q <= item.turn_right;
						left_q  <= item.turn_left;
						if (item.turn_right || item.turn_left)
							state_q <= ST_ANGLE;
						else
							done_q <= 1'b1;
					end
				end
				ST_ANGLE: begin
					cnt_q       <= '0;
					pass_left_q <= !right_q;
					state_q     <= ST_CORDIC;
				end
				ST_CORDIC: begin
					if (cnt_q == CNT_W'(CORDIC_STEPS - 1))
						state_q <= ST_SETUP;
					else
						cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_SETUP: begin
					bcnt_q  <= '0;
					state_q <= ST_ROTATE;
				end
				ST_ROTATE: begin
					if (last_bit)
						state_q <= ST_WRITE;
					else
						bcnt_q <= bcnt_q + VVR_BCNT_W'(1);
				end
				ST_WRITE: begin
					if (pass_left_q || !left_q) begin
						state_q <= ST_NONE;
						done_q  <= 1'b1;
					end else begin
						pass_left_q <= 1'b1;
						bcnt_q      <= '0;
						state_q     <= ST_ROTATE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// rate register and vector state: config writes, bit shifting, write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= VVR_RST_RATE;
			vec_q[0] <= VVR_RST_DIR_X;
			vec_q[1] <= VVR_RST_DIR_Y;
			vec_q[2] <= VVR_RST_PLANE_X;
			vec_q[3] <= VVR_RST_PLANE_Y;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_RATE:    rate_q   <= cfg_data[VVR_RATE_W-1:0];
					REG_DIR_X:   vec_q[0] <= cfg_data[VVR_VEC_W-1:0];
					REG_DIR_Y:   vec_q[1] <= cfg_data[VVR_VEC_W-1:0];
					REG_PLANE_X: vec_q[2] <= cfg_data[VVR_VEC_W-1:0];
					REG_PLANE_Y: vec_q[3] <= cfg_data[VVR_VEC_W-1:0];
					default: ;
				endcase
			end else if (state_q == ST_ROTATE) begin
				for (int i = 0; i < VVR_LANES; i++)
					vec_q[i] <= vec_q[i] >> 1;
			end else if (state_q == ST_WRITE) begin
				for (int i = 0; i < VVR_LANES; i++)
					vec_q[i] <= lane_sat[i];
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept)
			prod_q <= rate_q * item.frame_time;
		if (state_q == ST_ANGLE) begin
			x_q <= VVR_GAIN;
			y_q <= '0;
			z_q <= ang_clamp;
		end
		if (state_q == ST_CORDIC) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
		if (state_q == ST_SETUP) begin
			s_q  <= pass_left_q ? -y_q : y_q;
			sn_q <= pass_left_q ? y_q : -y_q;
			for (int i = 0; i < VVR_LANES; i++)
				h_q[i] <= '0;
		end
		if (state_q == ST_ROTATE) begin
			for (int i = 0; i < VVR_LANES; i++) begin
				h_q[i] <= lane_t[i][VVR_HW:1];
				l_q[i] <= {lane_t[i][0], l_q[i][VVR_VEC_W-1:1]};
			end
		end
		if (state_q == ST_WRITE && !pass_left_q && left_q) begin
			// second pass turns the other way
			s_q  <= sn_q;
			sn_q <= s_q;
			for (int i = 0; i < VVR_LANES; i++)
				h_q[i] <= '0;
		end
		if (load_result) begin
			result_q.moved       <= right_q || left_q;
			result_q.out_dir_x   <= vec_q[0];
			result_q.out_dir_y   <= vec_q[1];
			result_q.out_plane_x <= vec_q[2];
			result_q.out_plane_y <= vec_q[3];
		end
	end

endmodule
